// ===== rtl/vfdcs_pkg.sv =====
// types and constants shared by the serial command sender modules
package vfdcs_pkg;

  // request operation codes
  localparam logic [3:0] OP_BLINK     = 4'd0;
  localparam logic [3:0] OP_ONOFF     = 4'd1;
  localparam logic [3:0] OP_SHIFT     = 4'd2;
  localparam logic [3:0] OP_GRIDLOAD  = 4'd3;
  localparam logic [3:0] OP_SETADDR   = 4'd4;
  localparam logic [3:0] OP_INTENSITY = 4'd5;
  localparam logic [3:0] OP_DCRAM     = 4'd6;
  localparam logic [3:0] OP_ADRAM     = 4'd7;
  localparam logic [3:0] OP_CGRAM     = 4'd8;

  // command opcodes placed in the packed word
  localparam logic [2:0] CMD_BLINK     = 3'h5;
  localparam logic [2:0] CMD_ONOFF     = 3'h1;
  localparam logic [2:0] CMD_SHIFT     = 3'h2;
  localparam logic [2:0] CMD_GRIDLOAD  = 3'h3;
  localparam logic [2:0] CMD_SETADDR   = 3'h4;
  localparam logic [2:0] CMD_INTENSITY = 3'h5;
  localparam logic [2:0] CMD_DCRAM     = 3'h6;
  localparam logic [2:0] CMD_ADRAM     = 3'h7;
  localparam logic [3:0] CMD_CGRAM     = 4'h8;

  // configuration register indexes
  localparam logic [1:0] REG_CHIP_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_BIT_HALF_PERIOD = 2'd1;
  localparam logic [1:0] REG_COMPLETION_WAIT = 2'd2;

  localparam int WORD_W      = 56;
  localparam int ADDR_BITS   = 8;
  localparam int SHORT_BITS  = 24;
  localparam int LONG_BITS   = 56;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              long_cmd;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  chip_address;
    logic [7:0]  bit_half_period;
    logic [15:0] completion_wait;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

endpackage

// ===== rtl/vfdcs_front.sv =====
// request decode and command word packing
module vfdcs_front import vfdcs_pkg::*; (
  input  logic        push,
  input  logic        fifo_full,
  input  logic [3:0]  operation,
  input  logic [1:0]  target_memory,
  input  logic        flag_bit,
  input  logic [2:0]  blink_period,
  input  logic [15:0] digit_mask,
  input  logic [3:0]  grid_count,
  input  logic [5:0]  char_address,
  input  logic [3:0]  dot_address,
  input  logic [7:0]  pattern_address,
  input  logic [7:0]  byte_value,
  input  logic [34:0] pattern_dots,
  output logic        fifo_push,
  output cmd_t        cmd
);

  logic known;

  always_comb begin
    known         = 1'b1;
    cmd.word      = '0;
    cmd.long_cmd  = 1'b0;
    case (operation)
      OP_BLINK: begin
        cmd.word[23:21] = CMD_BLINK;
        cmd.word[20:19] = target_memory;
        cmd.word[18:16] = blink_period;
        cmd.word[15:0]  = digit_mask;
      end
      OP_ONOFF: begin
        cmd.word[22:20] = CMD_ONOFF;
        cmd.word[18:17] = target_memory;
        cmd.word[16]    = flag_bit;
        cmd.word[15:0]  = digit_mask;
      end
      OP_SHIFT: begin
        cmd.word[22:20] = CMD_SHIFT;
        cmd.word[18:17] = target_memory;
        cmd.word[16]    = flag_bit;
      end
      OP_GRIDLOAD: begin
        cmd.word[22:20] = CMD_GRIDLOAD;
        cmd.word[19:16] = grid_count;
      end
      OP_SETADDR: begin
        cmd.word[22:20] = CMD_SETADDR;
        cmd.word[19:16] = dot_address;
        cmd.word[13:8]  = char_address;
      end
      OP_INTENSITY: begin
        cmd.word[22:20] = CMD_INTENSITY;
        cmd.word[15:8]  = byte_value;
      end
      OP_DCRAM: begin
        cmd.word[22:20] = CMD_DCRAM;
        cmd.word[13:8]  = char_address;
        cmd.word[7:0]   = byte_value;
      end
      OP_ADRAM: begin
        cmd.word[22:20] = CMD_ADRAM;
        cmd.word[19:16] = dot_address;
        cmd.word[15:8]  = byte_value;
      end
      OP_CGRAM: begin
        cmd.word[55:52] = CMD_CGRAM;
        cmd.word[47:40] = pattern_address;
        cmd.word[34:0]  = pattern_dots;
        cmd.long_cmd    = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown codes are taken and dropped
  assign fifo_push = push && !fifo_full && known;

endmodule

// ===== rtl/vfdcs_cmd_fifo.sv =====
// short command queue between decode and the serial engine
module vfdcs_cmd_fifo import vfdcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a write");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/vfdcs_back.sv =====
// serial engine: bit timing, address and data phases, completion wait
module vfdcs_back import vfdcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fifo_empty,
  input  cmd_t head,
  output logic fifo_pop,
  input  logic pop,
  output logic empty,
  output logic enable_level,
  output logic serial_bit,
  output logic last_bit
);

  phase_t            state, state_next;
  logic [WORD_W-1:0] shift_word, shift_word_next;
  logic [7:0]        addr_shift, addr_shift_next;
  logic              long_cmd, long_cmd_next;
  logic [6:0]        bits_left, bits_left_next;
  logic [15:0]       wait_counter, wait_counter_next;
  logic [7:0]        timer, timer_next;
  logic              second_half, second_half_next;
  logic              out_valid, out_valid_next;
  logic              out_en, out_en_next;
  logic              out_bit, out_bit_next;
  logic              out_last, out_last_next;
  logic              tick;
  logic              slot_free;
  logic              sending;
  logic              emit;

  assign tick      = ({1'b0, timer} + 9'd1) >= {1'b0, cfg.bit_half_period};
  assign slot_free = !out_valid || pop;
  assign sending   = (state == PH_ADDR) || (state == PH_DATA);
  assign emit      = sending && second_half && tick && slot_free;

  always_comb begin
    state_next        = state;
    shift_word_next   = shift_word;
    addr_shift_next   = addr_shift;
    long_cmd_next     = long_cmd;
    bits_left_next    = bits_left;
    wait_counter_next = wait_counter;
    timer_next        = timer;
    second_half_next  = second_half;
    out_valid_next    = out_valid;
    out_en_next       = out_en;
    out_bit_next      = out_bit;
    out_last_next     = out_last;
    fifo_pop          = 1'b0;

    if (out_valid && pop) begin
      out_valid_next = 1'b0;
    end

    // half period timer, held at the end of a bit until the slot frees
    if (!sending) begin
      timer_next       = '0;
      second_half_next = 1'b0;
    end else if (tick) begin
      if (!second_half) begin
        second_half_next = 1'b1;
        timer_next       = '0;
      end else if (slot_free) begin
        second_half_next = 1'b0;
        timer_next       = '0;
      end
    end else begin
      timer_next = timer + 1'b1;
    end

    case (state)
      PH_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop        = 1'b1;
          shift_word_next = head.word;
          long_cmd_next   = head.long_cmd;
          addr_shift_next = cfg.chip_address;
          bits_left_next  = 7'(ADDR_BITS);
          state_next      = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (emit) begin
          out_valid_next  = 1'b1;
          out_en_next     = 1'b0;
          out_bit_next    = addr_shift[0];
          out_last_next   = 1'b0;
          addr_shift_next = addr_shift >> 1;
          if (bits_left == 7'd1) begin
            bits_left_next = long_cmd ? 7'(LONG_BITS) : 7'(SHORT_BITS);
            state_next     = PH_DATA;
          end else begin
            bits_left_next = bits_left - 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (emit) begin
          out_valid_next  = 1'b1;
          out_en_next     = 1'b1;
          out_bit_next    = shift_word[0];
          out_last_next   = (bits_left == 7'd1);
          shift_word_next = shift_word >> 1;
          bits_left_next  = bits_left - 1'b1;
          if (bits_left == 7'd1) begin
            wait_counter_next = cfg.completion_wait;
            state_next = (cfg.completion_wait != '0) ? PH_WAIT : PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        if (wait_counter <= 16'd1) begin
          wait_counter_next = '0;
          state_next        = PH_IDLE;
        end else begin
          wait_counter_next = wait_counter - 1'b1;
        end
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    shift_word <= shift_word_next;
    addr_shift <= addr_shift_next;
    long_cmd   <= long_cmd_next;
    out_en     <= out_en_next;
    out_bit    <= out_bit_next;
    out_last   <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PH_IDLE;
      bits_left    <= '0;
      wait_counter <= '0;
      timer        <= '0;
      second_half  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      bits_left    <= bits_left_next;
      wait_counter <= wait_counter_next;
      timer        <= timer_next;
      second_half  <= second_half_next;
      out_valid    <= out_valid_next;
    end
  end

  assign empty        = !out_valid;
  assign enable_level = out_en;
  assign serial_bit   = out_bit;
  assign last_bit     = out_last;

`ifndef ASSERT_OFF
  a_last_in_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> out_en)
    else $error("last bit outside the data phase");
  a_addr_count: assert property (@(posedge clk) disable iff (rst)
    (state == PH_ADDR) |-> (bits_left != '0 && bits_left <= 7'(ADDR_BITS)))
    else $error("address bit count out of range");
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (state == PH_DATA) |-> (bits_left != '0 && bits_left <= 7'(LONG_BITS)))
    else $error("data bit count out of range");
  a_end_of_cmd: assert property (@(posedge clk) disable iff (rst)
    (emit && state == PH_DATA && bits_left == 7'd1)
      |=> (out_valid && out_last && (state == PH_WAIT || state == PH_IDLE)))
    else $error("command did not close after its last bit");
`endif

endmodule

// ===== rtl/vfd_serial_command_sender.sv =====
// top level of the display controller serial command sender
// Each accepted request becomes one serial transfer: the 8-bit chip_address is sent
// with enable low, then the packed command word with enable high, least significant
// bit first; every bit is delivered as one result (32 per command, 64 for a pattern
// RAM write) and last_bit marks the final command bit. Unknown operation codes
// (9 to 15) are accepted and dropped without any result. The bit timer of the
// serial engine sends each bit as two half periods set by bit_half_period, and
// after the last bit its completion wait counter keeps the engine busy for a wait
// set by completion_wait before it picks up the next command. A two-deep command
// queue sits in front of the engine, so up to two further requests are taken while
// one is on the wire, and a one-entry result register lets the engine run ahead by
// one bit of a slow consumer; a stalled result simply holds the bit timer.
// Configuration registers (index 0 chip_address, 1 bit_half_period,
// 2 completion_wait) are always ready and are meant to be written while idle.
module vfd_serial_command_sender import vfdcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [3:0]  operation,
  input  logic [1:0]  target_memory,
  input  logic        flag_bit,
  input  logic [2:0]  blink_period,
  input  logic [15:0] digit_mask,
  input  logic [3:0]  grid_count,
  input  logic [5:0]  char_address,
  input  logic [3:0]  dot_address,
  input  logic [7:0]  pattern_address,
  input  logic [7:0]  byte_value,
  input  logic [34:0] pattern_dots,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        enable_level,
  output logic        serial_bit,
  output logic        last_bit,
  // configuration write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head;
  logic fifo_push;
  logic fifo_pop;
  logic fifo_full;
  logic fifo_empty;

  // configuration registers, writes beyond the list are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chip_address    <= 8'd0;
      cfg.bit_half_period <= 8'd25;
      cfg.completion_wait <= 16'd1250;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHIP_ADDRESS:    cfg.chip_address    <= cfg_data[7:0];
        REG_BIT_HALF_PERIOD: cfg.bit_half_period <= cfg_data[7:0];
        REG_COMPLETION_WAIT: cfg.completion_wait <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // requests are refused only while the command queue is full
  assign full = fifo_full;

  vfdcs_front u_front (
    .push            (push),
    .fifo_full       (fifo_full),
    .operation       (operation),
    .target_memory   (target_memory),
    .flag_bit        (flag_bit),
    .blink_period    (blink_period),
    .digit_mask      (digit_mask),
    .grid_count      (grid_count),
    .char_address    (char_address),
    .dot_address     (dot_address),
    .pattern_address (pattern_address),
    .byte_value      (byte_value),
    .pattern_dots    (pattern_dots),
    .fifo_push       (fifo_push),
    .cmd             (front_cmd)
  );

  vfdcs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fifo_push),
    .push_cmd (front_cmd),
    .pop      (fifo_pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  vfdcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fifo_empty   (fifo_empty),
    .head         (head),
    .fifo_pop     (fifo_pop),
    .pop          (pop),
    .empty        (empty),
    .enable_level (enable_level),
    .serial_bit   (serial_bit),
    .last_bit     (last_bit)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    fifo_full |-> !fifo_push)
    else $error("command written into a full queue");
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("engine took a command from an empty queue");
  a_known_ops_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && operation <= OP_CGRAM) |-> fifo_push)
    else $error("valid request not queued");
`endif

endmodule
